FILE: hdl/alu64_pkg.sv
// Package: types and constants for the 64-bit integer ALU.
package alu64_pkg;

  localparam int unsigned HalfWidthDef = 32;
  localparam int unsigned FieldWidth = 64;

  typedef enum logic [2:0] {
    OpAdd = 3'd0,
    OpSub = 3'd1,
    OpMul = 3'd2,
    OpDiv = 3'd3,
    OpEq  = 3'd4,
    OpLt  = 3'd5,
    OpGt  = 3'd6,
    OpNop = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]            kind;
    logic [FieldWidth-1:0] a_operand;
    logic [FieldWidth-1:0] b_operand;
  } in_beat_t;

  typedef struct packed {
    logic [FieldWidth-1:0] result_value;
    logic                  compare_true;
    logic                  divide_by_zero;
  } out_beat_t;

endpackage

FILE: hdl/alu64_add_sub_mul_div_compare_core.sv
// Top level: pipelined 64-bit integer ALU, one beat per cycle when not stalled.
//
// Accepts one operation per cycle while the output is not stalled and returns
// one result per beat in order. The longest path is the restoring divider, one
// quotient bit per pipeline stage; the other operations ride along the same
// stages. Stage 1 holds the three half-width partial products of a multiply,
// and the output stage sums them. A stall freezes the whole pipeline; the input
// is ready whenever the output stage is empty or being drained.
module alu64_add_sub_mul_div_compare_core #(
  parameter int unsigned HALF_WIDTH = alu64_pkg::HalfWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  alu64_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output alu64_pkg::out_beat_t out_data_o
);

  localparam int unsigned W = 2 * HALF_WIDTH;
  localparam int unsigned H = HALF_WIDTH;
  localparam int unsigned NDiv = W;
  localparam int unsigned NStg = NDiv + 3;

  typedef struct packed {
    logic [2:0]   kind;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] res;
    logic [W:0]   rem;
    logic         flag;
    logic         dz;
  } stage_t;

  logic   advance;
  logic   [NStg-1:0] vld_q;
  stage_t stg_q [NStg];
  stage_t stg_d [NStg];
  stage_t stg0_d;

  logic [W-1:0] pll_q, plh_q, phl_q;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  // Stage 0: capture, add/sub/compare, divide-by-zero check.
  logic [W-1:0] a0, b0;
  logic [H:0]   lo_sum, hi_sum;
  logic         brw;
  assign a0 = in_data_i.a_operand[W-1:0];
  assign b0 = in_data_i.b_operand[W-1:0];

  always_comb begin
    stg0_d      = '0;
    stg0_d.kind = in_data_i.kind;
    stg0_d.a    = a0;
    stg0_d.b    = b0;
    lo_sum      = '0;
    hi_sum      = '0;
    brw         = 1'b0;
    case (alu64_pkg::op_e'(in_data_i.kind))
      alu64_pkg::OpAdd: begin
        lo_sum = {1'b0, a0[H-1:0]} + {1'b0, b0[H-1:0]};
        hi_sum = {1'b0, a0[W-1:H]} + {1'b0, b0[W-1:H]} + {{H{1'b0}}, lo_sum[H]};
        stg0_d.res = {hi_sum[H-1:0], lo_sum[H-1:0]};
      end
      alu64_pkg::OpSub: begin
        brw    = a0[H-1:0] < b0[H-1:0];
        lo_sum = {1'b0, a0[H-1:0]} - {1'b0, b0[H-1:0]};
        hi_sum = {1'b0, a0[W-1:H]} - {1'b0, b0[W-1:H]} - {{H{1'b0}}, brw};
        stg0_d.res = {hi_sum[H-1:0], lo_sum[H-1:0]};
      end
      alu64_pkg::OpDiv: begin
        if (b0 == '0) begin
          stg0_d.res = '1;
          stg0_d.dz  = 1'b1;
        end
      end
      alu64_pkg::OpEq: stg0_d.flag = a0 == b0;
      alu64_pkg::OpLt: stg0_d.flag = a0 < b0;
      alu64_pkg::OpGt: stg0_d.flag = a0 > b0;
      default: ;
    endcase
  end

  // Stage 1: partial products; later stages: one divide bit each; output stage: multiply sum.
  logic [W:0] trial [NDiv];
  always_comb begin
    stg_d[0] = stg0_d;
    stg_d[1] = stg_q[0];
    for (int s = 2; s < NStg; s++) begin
      stg_d[s] = stg_q[s-1];
    end
    for (int k = 0; k < NDiv; k++) begin
      trial[k] = {stg_q[k+1].rem[W-1:0], stg_q[k+1].a[W-1-k]};
      if (alu64_pkg::op_e'(stg_q[k+1].kind) == alu64_pkg::OpDiv && !stg_q[k+1].dz) begin
        if (trial[k] >= {1'b0, stg_q[k+1].b}) begin
          stg_d[k+2].rem = trial[k] - {1'b0, stg_q[k+1].b};
          stg_d[k+2].res[W-1-k] = 1'b1;
        end else begin
          stg_d[k+2].rem = trial[k];
        end
      end
    end
    if (alu64_pkg::op_e'(stg_q[NStg-2].kind) == alu64_pkg::OpMul) begin
      stg_d[NStg-1].res = pll_q + {plh_q[H-1:0] + phl_q[H-1:0], {H{1'b0}}};
    end
  end

  // Multiply partials carried in side registers; held across stalls.
  logic [W-1:0] ll_q [NStg-2];
  logic [W-1:0] lh_q [NStg-2];
  logic [W-1:0] hl_q [NStg-2];
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ll_q[0] <= stg_q[0].a[H-1:0] * stg_q[0].b[H-1:0];
      lh_q[0] <= stg_q[0].a[H-1:0] * stg_q[0].b[W-1:H];
      hl_q[0] <= stg_q[0].a[W-1:H] * stg_q[0].b[H-1:0];
      for (int s = 1; s < NStg - 2; s++) begin
        ll_q[s] <= ll_q[s-1];
        lh_q[s] <= lh_q[s-1];
        hl_q[s] <= hl_q[s-1];
      end
    end
  end
  assign pll_q = ll_q[NStg-3];
  assign plh_q = lh_q[NStg-3];
  assign phl_q = hl_q[NStg-3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int s = 0; s < NStg; s++) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  assign out_valid_o                = vld_q[NStg-1];
  assign out_data_o.result_value    = alu64_pkg::FieldWidth'(stg_q[NStg-1].res);
  assign out_data_o.compare_true    = stg_q[NStg-1].flag;
  assign out_data_o.divide_by_zero  = stg_q[NStg-1].dz;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed during stall");
  a_dz_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_by_zero |-> out_data_o.result_value[W-1:0] == '1
      && !out_data_o.compare_true)
    else $error("divide by zero result not all ones");
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.compare_true |-> out_data_o.result_value == '0)
    else $error("compare with nonzero value");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline stalled while output empty");
`endif

endmodule

FILE: dv/testbench.sv
// Testbench for the 64-bit integer ALU core: directed table plus random beats.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfW = alu64_pkg::HalfWidthDef;
  localparam int unsigned WordW = 2 * HalfW;
  localparam int unsigned Latency = 2 * HalfW + 3;
  localparam int unsigned NumRandom = 1600;
  localparam longint unsigned CycleLimit = 400000;

  typedef struct {
    alu64_pkg::in_beat_t  stim;
    logic                 known;
    alu64_pkg::out_beat_t want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  alu64_pkg::in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  alu64_pkg::out_beat_t out_data_o;

  alu64_pkg::out_beat_t results_pending[$];
  int unsigned fail_count = 0;
  int unsigned checked_count = 0;
  int unsigned dz_count = 0;
  longint unsigned cycle_count = 0;
  bit sending_done = 1'b0;
  bit calm_phase = 1'b0;
  bit hold_off = 1'b0;
  row_t directed[$];

  alu64_add_sub_mul_div_compare_core #(.HALF_WIDTH(HalfW)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic alu64_pkg::out_beat_t alu_compute(alu64_pkg::in_beat_t beat);
    logic [WordW-1:0] a, b;
    logic [HalfW:0] lo;
    logic [HalfW-1:0] hi;
    logic borrow;
    alu64_pkg::out_beat_t r;
    a = beat.a_operand[WordW-1:0];
    b = beat.b_operand[WordW-1:0];
    r = '0;
    case (alu64_pkg::op_e'(beat.kind))
      alu64_pkg::OpAdd: begin
        lo = {1'b0, a[HalfW-1:0]} + {1'b0, b[HalfW-1:0]};
        hi = a[WordW-1:HalfW] + b[WordW-1:HalfW] + lo[HalfW];
        r.result_value = {hi, lo[HalfW-1:0]};
      end
      alu64_pkg::OpSub: begin
        borrow = a[HalfW-1:0] < b[HalfW-1:0];
        hi = a[WordW-1:HalfW] - b[WordW-1:HalfW] - borrow;
        r.result_value = {hi, a[HalfW-1:0] - b[HalfW-1:0]};
      end
      alu64_pkg::OpMul: r.result_value = a * b;
      alu64_pkg::OpDiv: begin
        if (b == 0) begin
          r.result_value = {WordW{1'b1}};
          r.divide_by_zero = 1'b1;
        end else begin
          r.result_value = a / b;
        end
      end
      alu64_pkg::OpEq: r.compare_true = a == b;
      alu64_pkg::OpLt: r.compare_true = a < b;
      alu64_pkg::OpGt: r.compare_true = a > b;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 15));
      3: return {32'h0, $urandom()};
      4: return {$urandom(), 32'hffff_ffff};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic add_row(alu64_pkg::op_e op, logic [63:0] a, logic [63:0] b, logic known,
                         logic [63:0] v, logic f, logic dz);
    row_t r;
    r.stim = '{kind: op, a_operand: a, b_operand: b};
    r.known = known;
    r.want = '{result_value: v, compare_true: f, divide_by_zero: dz};
    directed.push_back(r);
  endtask

  task automatic send_beat(alu64_pkg::in_beat_t beat);
    int unsigned gap;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    results_pending.push_back(alu_compute(beat));
    @(negedge clk_i);
  endtask

  initial begin
    row_t r;
    alu64_pkg::in_beat_t beat;
    add_row(alu64_pkg::OpAdd, '1, 64'd1, 1'b1, '0, 1'b0, 1'b0);
    add_row(alu64_pkg::OpAdd, 64'hffff_ffff, 64'd1, 1'b1, 64'h1_0000_0000, 1'b0, 1'b0);
    add_row(alu64_pkg::OpAdd, '0, '0, 1'b1, '0, 1'b0, 1'b0);
    add_row(alu64_pkg::OpSub, '0, 64'd1, 1'b1, '1, 1'b0, 1'b0);
    add_row(alu64_pkg::OpSub, 64'h1_0000_0000, 64'd1, 1'b1, 64'hffff_ffff, 1'b0, 1'b0);
    add_row(alu64_pkg::OpSub, '1, '1, 1'b1, '0, 1'b0, 1'b0);
    add_row(alu64_pkg::OpMul, '1, '1, 1'b1, 64'd1, 1'b0, 1'b0);
    add_row(alu64_pkg::OpMul, 64'h1_0000_0000, 64'h1_0000_0000, 1'b1, '0, 1'b0, 1'b0);
    add_row(alu64_pkg::OpMul, 64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321, 1'b0, '0,
            1'b0, 1'b0);
    add_row(alu64_pkg::OpDiv, 64'd5, '0, 1'b1, '1, 1'b0, 1'b1);
    add_row(alu64_pkg::OpDiv, '0, '0, 1'b1, '1, 1'b0, 1'b1);
    add_row(alu64_pkg::OpDiv, '1, 64'd1, 1'b1, '1, 1'b0, 1'b0);
    add_row(alu64_pkg::OpDiv, '1, '1, 1'b1, 64'd1, 1'b0, 1'b0);
    add_row(alu64_pkg::OpDiv, 64'd7, 64'd8, 1'b1, '0, 1'b0, 1'b0);
    add_row(alu64_pkg::OpDiv, 64'hdead_beef_0123_4567, 64'h0000_0001_0000_0003, 1'b0, '0,
            1'b0, 1'b0);
    add_row(alu64_pkg::OpEq, '1, '1, 1'b1, '0, 1'b1, 1'b0);
    add_row(alu64_pkg::OpEq, '1, 64'hffff_ffff, 1'b1, '0, 1'b0, 1'b0);
    add_row(alu64_pkg::OpLt, '0, '1, 1'b1, '0, 1'b1, 1'b0);
    add_row(alu64_pkg::OpLt, '1, '1, 1'b1, '0, 1'b0, 1'b0);
    add_row(alu64_pkg::OpGt, '1, '0, 1'b1, '0, 1'b1, 1'b0);
    add_row(alu64_pkg::OpGt, '0, '0, 1'b1, '0, 1'b0, 1'b0);
    add_row(alu64_pkg::OpNop, '1, '1, 1'b1, '0, 1'b0, 1'b0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) begin
      r = directed[i];
      if (r.known && alu_compute(r.stim) !== r.want) begin
        $error("directed row %0d: table disagrees with predictor", i);
        fail_count++;
      end
      send_beat(r.stim);
    end
    hold_off = 1'b1;
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - 200) calm_phase = 1'b1;
      beat.kind = 3'($urandom_range(0, 7));
      beat.a_operand = rand_operand();
      beat.b_operand = rand_operand();
      if ($urandom_range(0, 3) == 0) beat.b_operand = beat.a_operand;
      send_beat(beat);
    end
    in_valid_i <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int unsigned burst;
    wait (hold_off);
    @(negedge clk_i);
    out_ready_i <= 1'b0;
    repeat (3 * Latency) @(negedge clk_i);
    forever begin
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 9);
        out_ready_i <= 1'b0;
        repeat (burst) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(negedge clk_i);
    end
  end

  initial begin
    wait (rst_ni);
    @(negedge clk_i);
    if (!hold_off) out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    alu64_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_pending.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = results_pending.pop_front();
        checked_count++;
        if (want.divide_by_zero) dz_count++;
        if (out_data_o.result_value !== want.result_value) begin
          $error("result_value: expected %h, actual %h", want.result_value,
                 out_data_o.result_value);
          fail_count++;
        end
        if (out_data_o.compare_true !== want.compare_true) begin
          $error("compare_true: expected %b, actual %b", want.compare_true,
                 out_data_o.compare_true);
          fail_count++;
        end
        if (out_data_o.divide_by_zero !== want.divide_by_zero) begin
          $error("divide_by_zero: expected %b, actual %b", want.divide_by_zero,
                 out_data_o.divide_by_zero);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    wait (results_pending.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    $display("checked %0d result beats, %0d of them divide by zero,", checked_count,
             dz_count);
    $display("with random stalls on both sides and one long output hold-off");
    if (fail_count == 0 && results_pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: alu64_add_sub_mul_div_compare_core.f
hdl/alu64_pkg.sv
hdl/alu64_add_sub_mul_div_compare_core.sv
dv/testbench.sv
